// File: rtl/sso_pkg.sv
// sso_pkg: shared types and constants of the sorted set-operation counter
// request and result payload structs, command codes and register indexes
// no dependencies
`default_nettype none

package sso_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int KEY_WIDTH           = 64;
   localparam int FLAG_WIDTH          = 32;
   localparam int REPEAT_WIDTH        = 32;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 32;

   typedef enum logic {
      CMD_ROW   = 1'b0,
      CMD_FLUSH = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OP_MODE         = 2'd0,
      CSR_KEEP_DUPLICATES = 2'd1,
      CSR_LEFT_FLAG_VALUE = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_INTERSECT = 1'b0,
      OP_EXCEPT    = 1'b1
   } op_mode_type;

   typedef struct packed {
      command_type             command;
      logic [KEY_WIDTH-1:0]    row_key;
      logic                    flag_present;
      logic signed [FLAG_WIDTH-1:0] flag_value;
   } req_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]    group_key;
      logic [REPEAT_WIDTH-1:0] repeat_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/sso_copy_count.sv
// sso_copy_count: copy count of a closed group from its left and right tallies
// intersect / except in distinct or all form, saturated to the result width
// depends on sso_pkg
`default_nettype none

module sso_copy_count #(
   parameter int COUNT_WIDTH = sso_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                    [COUNT_WIDTH-1:0] left_tally,
   input  wire logic                    [COUNT_WIDTH-1:0] right_tally,
   input  wire sso_pkg::op_mode_type                      op_mode,
   input  wire logic                                      keep_duplicates,
   output logic                                           emit,
   output logic [sso_pkg::REPEAT_WIDTH-1:0]               repeat_count
);
   import sso_pkg::*;

   localparam int WIDE = (COUNT_WIDTH > REPEAT_WIDTH) ? COUNT_WIDTH : REPEAT_WIDTH;

   logic [COUNT_WIDTH-1:0] copies;
   logic [WIDE-1:0]        copies_wide;
   logic                   l_nz;
   logic                   r_nz;

   always_comb begin
      l_nz = (left_tally != '0);
      r_nz = (right_tally != '0);
      unique case (op_mode)
         OP_INTERSECT: begin
            if (keep_duplicates) begin
               copies = (left_tally < right_tally) ? left_tally : right_tally;
            end else begin
               copies = COUNT_WIDTH'(l_nz && r_nz);
            end
         end
         OP_EXCEPT: begin
            if (keep_duplicates) begin
               copies = (left_tally > right_tally) ? (left_tally - right_tally) : '0;
            end else begin
               copies = COUNT_WIDTH'(l_nz && !r_nz);
            end
         end
         default: copies = '0;
      endcase
      copies_wide = WIDE'(copies);
      emit        = (copies != '0);
      if (copies_wide > WIDE'({REPEAT_WIDTH{1'b1}})) begin
         repeat_count = '1;
      end else begin
         repeat_count = copies_wide[REPEAT_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/sorted_set_operation_counter.sv
// sorted_set_operation_counter: top level of the sorted set-operation counter
// input register, group tally state and result register; uses sso_copy_count
// depends on sso_pkg
//
// usage:
//   req_* carries a key-sorted stream of rows and flush commands; a request is
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp_* returns one result per closed group that emits copies: the group
//   key and the repeat count. a result is taken when rsp_valid is high and
//   rsp_stall is low.
//   csr_* writes op_mode, keep_duplicates and left_flag_value, one per edge
//   with csr_write high; the user must write only while idle (not enforced).
// timing:
//   one request per cycle while req_stall is low. a request is registered,
//   then compared with the open group and folded into the tallies; a result
//   it causes is loaded into the result register when the request leaves
//   the input register.
// reset and stall:
//   reset clears the group, tallies, config registers and both valid flags.
//   while rsp_stall holds a result, a request that would close an emitting
//   group waits in the input register and req_stall rises.
`default_nettype none

module sorted_set_operation_counter #(
   parameter int COUNT_WIDTH = sso_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire sso_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output sso_pkg::rsp_type                           rsp_data,
   input  wire logic                                  csr_write,
   input  wire logic [sso_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [sso_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import sso_pkg::*;

   op_mode_type                   op_mode_ff;
   logic                          keep_dup_ff;
   logic signed [FLAG_WIDTH-1:0]  left_flag_ff;

   logic                          s1_valid_ff;
   req_type                       s1_data_ff;

   logic [KEY_WIDTH-1:0]          held_key_ff;
   logic                          open_ff;
   logic [COUNT_WIDTH-1:0]        left_ff;
   logic [COUNT_WIDTH-1:0]        right_ff;

   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   logic                          is_right;
   logic                          closing;
   logic                          copy_emit;
   logic [REPEAT_WIDTH-1:0]       copy_repeat;
   logic                          emit;
   logic                          out_free;
   logic                          s1_go;

   sso_copy_count #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_copy_count (
      .left_tally      (left_ff),
      .right_tally     (right_ff),
      .op_mode         (op_mode_ff),
      .keep_duplicates (keep_dup_ff),
      .emit            (copy_emit),
      .repeat_count    (copy_repeat)
   );

   always_comb begin
      is_right  = s1_data_ff.flag_present && (s1_data_ff.flag_value != left_flag_ff);
      closing   = open_ff && ((s1_data_ff.command == CMD_FLUSH) ||
                              (s1_data_ff.row_key != held_key_ff));
      emit      = s1_valid_ff && closing && copy_emit;
      out_free  = !rsp_valid_ff || !rsp_stall;
      s1_go     = s1_valid_ff && (!emit || out_free);
      req_stall = s1_valid_ff && !s1_go;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff   <= OP_INTERSECT;
         keep_dup_ff  <= 1'b0;
         left_flag_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OP_MODE:         op_mode_ff   <= op_mode_type'(csr_data[0]);
            CSR_KEEP_DUPLICATES: keep_dup_ff  <= csr_data[0];
            CSR_LEFT_FLAG_VALUE: left_flag_ff <= FLAG_WIDTH'(csr_data);
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         s1_data_ff <= req_data;
      end
   end

   // group state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         held_key_ff <= '0;
         left_ff     <= '0;
         right_ff    <= '0;
      end else if (s1_go) begin
         if (s1_data_ff.command == CMD_FLUSH) begin
            open_ff <= 1'b0;
         end else if (!open_ff || closing) begin
            open_ff     <= 1'b1;
            held_key_ff <= s1_data_ff.row_key;
            left_ff     <= COUNT_WIDTH'(!is_right);
            right_ff    <= COUNT_WIDTH'(is_right);
         end else if (is_right) begin
            right_ff <= (right_ff == '1) ? right_ff : right_ff + 1'b1;
         end else begin
            left_ff <= (left_ff == '1) ? left_ff : left_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_go && emit;
      end
      if (out_free && s1_go && emit) begin
         rsp_data_ff.group_key    <= held_key_ff;
         rsp_data_ff.repeat_count <= copy_repeat;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sso_checker.sv
// sso_checker: port-level checks of the sorted set-operation counter
// watches the request and result channels; bound to the top level below
// depends on sso_pkg
`default_nettype none

module sso_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sso_pkg::rsp_type rsp_data
);
   import sso_pkg::*;

   // a held result stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // no result ever carries zero copies
   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.repeat_count != '0)
      else $error("result with zero repeat count");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a new result needs a request that was taken and held in the input register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a request two cycles before");

endmodule

bind sorted_set_operation_counter sso_checker u_sso_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: test/sso_group_checker.sv
// sso_group_checker: watches the request, result and register ports of the
// sorted set-operation counter, predicts each closed group and compares results
// depends on sso_pkg
`default_nettype none

module sso_group_checker #(
   parameter int COUNT_WIDTH = sso_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_stall,
   input  wire sso_pkg::req_type                      req_data,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire sso_pkg::rsp_type                      rsp_data,
   input  wire logic                                  csr_write,
   input  wire logic [sso_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [sso_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   output int                                         mismatches,
   output int                                         pending,
   output int                                         groups_checked
);

   import sso_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] TALLY_FULL = '1;

   op_mode_type              mode;
   logic                     keep_all;
   logic [FLAG_WIDTH-1:0]    left_flag;
   logic [KEY_WIDTH-1:0]     open_key;
   logic                     open_valid;
   logic [COUNT_WIDTH-1:0]   left_rows;
   logic [COUNT_WIDTH-1:0]   right_rows;
   rsp_type                  expected_groups [$];

   initial begin
      mismatches     = 0;
      groups_checked = 0;
      pending        = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 100) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic count_row(input logic present, input logic [FLAG_WIDTH-1:0] flag);
      if (present && flag != left_flag) begin
         if (right_rows != TALLY_FULL) right_rows++;
      end else if (left_rows != TALLY_FULL) begin
         left_rows++;
      end
   endtask

   task automatic open_group(input req_type r);
      open_key   = r.row_key;
      open_valid = 1'b1;
      left_rows  = '0;
      right_rows = '0;
      count_row(r.flag_present, r.flag_value);
   endtask

   task automatic close_group();
      logic [63:0] l;
      logic [63:0] r;
      logic [63:0] copies;
      rsp_type     e;
      l = 64'(left_rows);
      r = 64'(right_rows);
      if (mode == OP_INTERSECT) begin
         if (keep_all) copies = (l < r) ? l : r;
         else copies = (l != 0 && r != 0) ? 64'd1 : 64'd0;
      end else begin
         if (keep_all) copies = (l > r) ? l - r : 64'd0;
         else copies = (l != 0 && r == 0) ? 64'd1 : 64'd0;
      end
      open_valid = 1'b0;
      if (copies != 0) begin
         e.group_key    = open_key;
         e.repeat_count = (copies > 64'hFFFF_FFFF) ? '1 : copies[REPEAT_WIDTH-1:0];
         expected_groups = {expected_groups, e};
      end
   endtask

   task automatic predict_request(input req_type r);
      if (r.command == CMD_FLUSH) begin
         if (open_valid) close_group();
      end else if (!open_valid) begin
         open_group(r);
      end else if (r.row_key == open_key) begin
         count_row(r.flag_present, r.flag_value);
      end else begin
         close_group();
         open_group(r);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      groups_checked++;
      if (expected_groups.size() == 0) begin
         report_mismatch($sformatf("unexpected result key %h count %0d",
                                   got.group_key, got.repeat_count));
         return;
      end
      want = expected_groups.pop_front();
      if (got.group_key !== want.group_key) begin
         report_mismatch($sformatf("group_key %h, expected %h",
                                   got.group_key, want.group_key));
      end
      if (got.repeat_count !== want.repeat_count) begin
         report_mismatch($sformatf("repeat_count %0d for key %h, expected %0d",
                                   got.repeat_count, want.group_key, want.repeat_count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode       = OP_INTERSECT;
         keep_all   = 1'b0;
         left_flag  = '0;
         open_key   = '0;
         open_valid = 1'b0;
         left_rows  = '0;
         right_rows = '0;
         expected_groups.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) predict_request(req_data);
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_OP_MODE:         mode = op_mode_type'(csr_data[0]);
               CSR_KEEP_DUPLICATES: keep_all = csr_data[0];
               CSR_LEFT_FLAG_VALUE: left_flag = csr_data[FLAG_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_groups.size();
   end

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench: drives sorted row streams, flushes and register settings into
// sorted_set_operation_counter and gives the verdict
// depends on sso_pkg, sorted_set_operation_counter and sso_group_checker
`default_nettype none

module testbench;

   import sso_pkg::*;

   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_ITEMS    = 80;

   typedef enum int {
      SIDE_LEFT,
      SIDE_RIGHT,
      SIDE_MISSING
   } side_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   req_type                      req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   rsp_type                      rsp_data;
   logic                         csr_write;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [CSR_DATA_WIDTH-1:0]    csr_data;

   int                           mismatches;
   int                           pending;
   int                           groups_checked;

   int                           holdoff_asks   = 0;
   int                           requests_sent  = 0;
   int                           settings_used  = 0;
   int                           burst_left     = 0;
   logic                         gaps_on        = 1'b1;
   logic [FLAG_WIDTH-1:0]        left_flag      = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_set_operation_counter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sso_group_checker group_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .pending        (pending),
      .groups_checked (groups_checked)
   );

   task automatic send_request(input command_type cmd, input logic [KEY_WIDTH-1:0] key,
                               input logic present, input logic [FLAG_WIDTH-1:0] flag);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else if (gaps_on) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_data  <= '{command: cmd, row_key: key, flag_present: present, flag_value: flag};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_row(input logic [KEY_WIDTH-1:0] key, input side_type side);
      logic [FLAG_WIDTH-1:0] other;
      if ($urandom_range(0, 1)) other = left_flag ^ (32'h1 << $urandom_range(0, 31));
      else other = left_flag ^ ($urandom() | 32'h1);
      case (side)
         SIDE_LEFT:  send_request(CMD_ROW, key, 1'b1, left_flag);
         SIDE_RIGHT: send_request(CMD_ROW, key, 1'b1, other);
         default:    send_request(CMD_ROW, key, 1'b0, $urandom());
      endcase
   endtask

   task automatic send_flush();
      send_request(CMD_FLUSH, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)), $urandom());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input op_mode_type op, input logic keep,
                           input logic [FLAG_WIDTH-1:0] flag);
      settle();
      csr_write <= 1'b1;
      csr_index <= CSR_OP_MODE;
      csr_data  <= ($urandom() & 32'hFFFF_FFFE) | 32'(op);
      @(posedge clock);
      csr_index <= CSR_KEEP_DUPLICATES;
      csr_data  <= ($urandom() & 32'hFFFF_FFFE) | 32'(keep);
      @(posedge clock);
      csr_index <= CSR_LEFT_FLAG_VALUE;
      csr_data  <= flag;
      @(posedge clock);
      csr_write <= 1'b0;
      left_flag = flag;
      settings_used++;
   endtask

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int seg_len;
      int stall_pct;
      int k;
      int holdoff_served;
      rsp_stall = 1'b0;
      holdoff_served = 0;
      forever begin
         seg_len = $urandom_range(10, 120);
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            2:       stall_pct = 70;
            default: stall_pct = 95;
         endcase
         for (k = 0; k < seg_len; k++) begin
            @(posedge clock);
            if (holdoff_asks != holdoff_served) begin
               holdoff_served++;
               rsp_stall <= 1'b1;
               repeat (HOLDOFF_CYCLES) @(posedge clock);
            end
            rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("timed out with %0d results outstanding", pending);
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      logic [FLAG_WIDTH-1:0] phase_flags [6];
      logic [FLAG_WIDTH-1:0] flag;
      logic [KEY_WIDTH-1:0]  next_key;
      logic [KEY_WIDTH-1:0]  prev_key;
      logic [KEY_WIDTH-1:0]  earlier_key;
      int                    p;
      int                    k;
      int                    rows;
      int                    lpct;
      int                    pick;
      int                    phase_items;

      phase_flags = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF, 32'h0000_0001, 32'h5A5A_A5A5};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: intersect distinct, left flag zero
      send_flush();
      send_row(64'h0, SIDE_LEFT);
      send_row(64'h0, SIDE_RIGHT);
      send_row(64'h0, SIDE_MISSING);
      send_row('1, SIDE_LEFT);
      send_row('1, SIDE_LEFT);
      send_flush();
      send_flush();
      send_row(64'd5, SIDE_RIGHT);
      send_row(64'd3, SIDE_LEFT);
      send_row(64'd3, SIDE_RIGHT);
      send_row(64'd5, SIDE_LEFT);
      send_row(64'd5, SIDE_RIGHT);
      send_flush();

      set_mode(OP_EXCEPT, 1'b1, 32'h8000_0000);
      send_row(64'd10, SIDE_LEFT);
      send_row(64'd10, SIDE_LEFT);
      send_row(64'd10, SIDE_LEFT);
      send_request(CMD_ROW, 64'd10, 1'b1, 32'h7FFF_FFFF);
      send_row(64'd11, SIDE_RIGHT);
      send_flush();

      set_mode(OP_INTERSECT, 1'b1, 32'h7FFF_FFFF);
      send_row(64'd20, SIDE_LEFT);
      send_row(64'd20, SIDE_MISSING);
      send_request(CMD_ROW, 64'd20, 1'b1, 32'h8000_0000);
      send_row(64'd20, SIDE_RIGHT);
      send_row(64'd20, SIDE_RIGHT);
      send_flush();

      for (p = 0; p < 8; p++) begin
         flag = (p < 6) ? phase_flags[p] : $urandom();
         set_mode(op_mode_type'(p[0]), p[1], flag);
         gaps_on = (p != 4);
         if (p == 2) holdoff_asks++;
         next_key    = {$urandom(), $urandom()};
         prev_key    = next_key;
         earlier_key = next_key;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(1, 100);
            if (pick <= 80) begin
               rows = ($urandom_range(1, 8) == 1) ? $urandom_range(6, 24) : $urandom_range(1, 5);
               lpct = $urandom_range(0, 100);
               for (k = 0; k < rows; k++) begin
                  if ($urandom_range(1, 100) <= 15) send_row(next_key, SIDE_MISSING);
                  else if ($urandom_range(1, 100) <= lpct) send_row(next_key, SIDE_LEFT);
                  else send_row(next_key, SIDE_RIGHT);
               end
               phase_items += rows;
               earlier_key = prev_key;
               prev_key    = next_key;
               next_key    = next_key + $urandom_range(1, 4096);
            end else if (pick <= 88) begin
               send_flush();
               phase_items++;
            end else if (pick <= 95) begin
               send_request(CMD_ROW, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
                            $urandom());
               phase_items++;
            end else begin
               // a key from an earlier group comes back out of order
               send_row(earlier_key, side_type'($urandom_range(0, 2)));
               phase_items++;
            end
         end
      end

      send_flush();
      settle();
      repeat (8) @(posedge clock);
      $display("run covered %0d requests and %0d results over %0d register settings",
               requests_sent, groups_checked, settings_used);
      if (mismatches == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
